/* sv/inv3_pkg.sv */
// ----------------------------------------------------------------------------
// inv3_pkg
// Shared types and constants for the 3x3 fixed-point matrix inverse.
// ----------------------------------------------------------------------------
package inv3_pkg;

    localparam int ELEM_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int ADJ_W         = 2 * ELEM_W + 1;
    localparam int DABS_W        = 3 * ELEM_W;
    localparam int QUO_W         = ELEM_W + 1;
    localparam int FRONT_STAGES  = 6;

    typedef logic signed [ELEM_W-1:0] elem_t;

    localparam elem_t ELEM_MAX = {1'b0, {(ELEM_W - 1){1'b1}}};
    localparam elem_t ELEM_MIN = {1'b1, {(ELEM_W - 1){1'b0}}};

    typedef struct packed {
        elem_t in_r1c1;
        elem_t in_r1c2;
        elem_t in_r1c3;
        elem_t in_r2c1;
        elem_t in_r2c2;
        elem_t in_r2c3;
        elem_t in_r3c1;
        elem_t in_r3c2;
        elem_t in_r3c3;
    } mat_t;

    typedef struct packed {
        elem_t out_r1c1;
        elem_t out_r1c2;
        elem_t out_r1c3;
        elem_t out_r2c1;
        elem_t out_r2c2;
        elem_t out_r2c3;
        elem_t out_r3c1;
        elem_t out_r3c2;
        elem_t out_r3c3;
        elem_t determinant;
        logic  singular;
    } inv_t;

    typedef struct packed {
        logic       singular;
        logic [8:0] sneg;
        elem_t      det;
    } side_t;

endpackage

/* sv/inv3_front.sv */
// ----------------------------------------------------------------------------
// inv3_front
// Cofactors, determinant and divider operand preparation (six stages).
// ----------------------------------------------------------------------------
module inv3_front
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic [FRONT_STAGES-1:0]                      en,
    input  logic                                         valid_in,
    input  mat_t                                         mat,
    output logic [FRONT_STAGES-1:0]                      vld,
    output logic [8:0][2*ELEM_W+2*FRAC_BITS-1:0]         rem,
    output logic [DABS_W-1:0]                            dabs,
    output side_t                                        side
);

    localparam int NW     = 2 * ELEM_W + 2 * FRAC_BITS;
    localparam int PROD_W = 2 * ELEM_W;
    localparam int PART_W = 2 * ELEM_W + 1;
    localparam int DET_W  = 3 * ELEM_W + 1;
    localparam int COF [9][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    elem_t e [9];

    logic [FRONT_STAGES-1:0] vld_reg;
    logic [FRONT_STAGES-1:0] vld_next;

    logic signed [PROD_W-1:0] pa_reg [9];
    logic signed [PROD_W-1:0] pb_reg [9];
    elem_t                    e1_reg [3];
    logic signed [ADJ_W-1:0]  adj2_reg [9];
    elem_t                    e2_reg [3];
    logic signed [PART_W-1:0] pl_reg [3];
    logic signed [PART_W-1:0] ph_reg [3];
    logic signed [ADJ_W-1:0]  adj3_reg [9];
    logic signed [DET_W-1:0]  term_reg [3];
    logic signed [ADJ_W-1:0]  adj4_reg [9];
    logic signed [DET_W-1:0]  det_reg;
    logic signed [ADJ_W-1:0]  adj5_reg [9];

    logic [8:0][NW-1:0]       rem_reg;
    logic [8:0][NW-1:0]       rem_next;
    logic [DABS_W-1:0]        dabs_reg;
    logic [DABS_W-1:0]        dabs_next;
    side_t                    side_reg;
    side_t                    side_next;

    logic                     dneg;
    logic signed [DET_W-1:0]  dmag;
    logic [DABS_W-1:0]        dq;
    logic signed [ADJ_W-1:0]  amag [9];

    assign e[0] = mat.in_r1c1;
    assign e[1] = mat.in_r1c2;
    assign e[2] = mat.in_r1c3;
    assign e[3] = mat.in_r2c1;
    assign e[4] = mat.in_r2c2;
    assign e[5] = mat.in_r2c3;
    assign e[6] = mat.in_r3c1;
    assign e[7] = mat.in_r3c2;
    assign e[8] = mat.in_r3c3;

    assign vld_next = {vld_reg[FRONT_STAGES-2:0], valid_in};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int i = 0; i < FRONT_STAGES; i++)
            begin
                if (en[i])
                begin
                    vld_reg[i] <= vld_next[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 9; k++)
            begin
                pa_reg[k] <= e[COF[k][0]] * e[COF[k][1]];
                pb_reg[k] <= e[COF[k][2]] * e[COF[k][3]];
            end
            for (int j = 0; j < 3; j++)
            begin
                e1_reg[j] <= e[j];
            end
        end
        if (en[1])
        begin
            for (int k = 0; k < 9; k++)
            begin
                adj2_reg[k] <= ADJ_W'(pa_reg[k]) - ADJ_W'(pb_reg[k]);
            end
            e2_reg <= e1_reg;
        end
        if (en[2])
        begin
            for (int j = 0; j < 3; j++)
            begin
                pl_reg[j] <= e2_reg[j] * $signed({1'b0, adj2_reg[3*j][ELEM_W-1:0]});
                ph_reg[j] <= e2_reg[j] * $signed(adj2_reg[3*j][ADJ_W-1:ELEM_W]);
            end
            adj3_reg <= adj2_reg;
        end
        if (en[3])
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= (DET_W'(ph_reg[j]) <<< ELEM_W) + DET_W'(pl_reg[j]);
            end
            adj4_reg <= adj3_reg;
        end
        if (en[4])
        begin
            det_reg  <= term_reg[0] + term_reg[1] + term_reg[2];
            adj5_reg <= adj4_reg;
        end
        if (en[5])
        begin
            rem_reg  <= rem_next;
            dabs_reg <= dabs_next;
            side_reg <= side_next;
        end
    end

    always_comb
    begin
        dneg      = det_reg[DET_W-1];
        dmag      = dneg ? -det_reg : det_reg;
        dabs_next = dmag[DABS_W-1:0];
        dq        = dabs_next >> (2 * FRAC_BITS);

        side_next.singular = (dq == '0);
        if (|dq[DABS_W-1:ELEM_W-1])
        begin
            side_next.det = dneg ? ELEM_MIN : ELEM_MAX;
        end
        else
        begin
            side_next.det = dneg ? -elem_t'(dq[ELEM_W-1:0]) : elem_t'(dq[ELEM_W-1:0]);
        end

        for (int k = 0; k < 9; k++)
        begin
            amag[k]           = adj5_reg[k][ADJ_W-1] ? -adj5_reg[k] : adj5_reg[k];
            rem_next[k]       = NW'(amag[k][2*ELEM_W-1:0]) << (2 * FRAC_BITS);
            side_next.sneg[k] = adj5_reg[k][ADJ_W-1] ^ dneg;
        end
    end

    assign vld  = vld_reg;
    assign rem  = rem_reg;
    assign dabs = dabs_reg;
    assign side = side_reg;

endmodule

/* sv/inv3_div_step.sv */
// ----------------------------------------------------------------------------
// inv3_div_step
// One quotient bit of the nine-lane restoring divider.
// ----------------------------------------------------------------------------
module inv3_div_step
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    parameter int BIT       = 0
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic                                 valid_in,
    input  logic [8:0][2*ELEM_W+2*FRAC_BITS-1:0] rem_in,
    input  logic [8:0][QUO_W-1:0]                quo_in,
    input  logic [DABS_W-1:0]                    dabs_in,
    input  side_t                                side_in,
    output logic                                 vld,
    output logic [8:0][2*ELEM_W+2*FRAC_BITS-1:0] rem,
    output logic [8:0][QUO_W-1:0]                quo,
    output logic [DABS_W-1:0]                    dabs,
    output side_t                                side
);

    localparam int NW = 2 * ELEM_W + 2 * FRAC_BITS;
    localparam int XW = (NW > DABS_W) ? NW : DABS_W;
    localparam int SW = (NW > DABS_W + QUO_W) ? NW : DABS_W + QUO_W;

    logic                vld_reg;
    logic [8:0][NW-1:0]  rem_reg;
    logic [8:0][NW-1:0]  rem_next;
    logic [8:0][QUO_W-1:0] quo_reg;
    logic [8:0][QUO_W-1:0] quo_next;
    logic [DABS_W-1:0]   dabs_reg;
    side_t               side_reg;
    logic [SW-1:0]       dsh;
    logic [8:0]          hit;

    always_comb
    begin
        dsh = SW'(dabs_in) << BIT;
        for (int k = 0; k < 9; k++)
        begin
            hit[k]           = XW'(rem_in[k] >> BIT) >= XW'(dabs_in);
            rem_next[k]      = hit[k] ? (rem_in[k] - dsh[NW-1:0]) : rem_in[k];
            quo_next[k]      = quo_in[k];
            quo_next[k][BIT] = hit[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            quo_reg  <= quo_next;
            dabs_reg <= dabs_in;
            side_reg <= side_in;
        end
    end

    assign vld  = vld_reg;
    assign rem  = rem_reg;
    assign quo  = quo_reg;
    assign dabs = dabs_reg;
    assign side = side_reg;

endmodule

/* sv/inv3_back.sv */
// ----------------------------------------------------------------------------
// inv3_back
// Sign, saturation and singular substitution into the output register.
// ----------------------------------------------------------------------------
module inv3_back
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  valid_in,
    input  logic [8:0][QUO_W-1:0] quo_in,
    input  side_t                 side_in,
    output logic                  vld,
    output inv_t                  res
);

    localparam elem_t ONE = (FRAC_BITS < ELEM_W - 1) ?
                            elem_t'(64'd1 << FRAC_BITS) : ELEM_MAX;

    logic  vld_reg;
    inv_t  res_reg;
    inv_t  res_next;
    elem_t val [9];
    elem_t mag [9];

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            mag[k] = quo_in[k][ELEM_W-1:0];
            if (side_in.singular)
            begin
                val[k] = (k % 4 == 0) ? ONE : '0;
            end
            else if (!side_in.sneg[k])
            begin
                val[k] = (quo_in[k][ELEM_W] || quo_in[k][ELEM_W-1]) ? ELEM_MAX : mag[k];
            end
            else if (quo_in[k][ELEM_W] || (quo_in[k][ELEM_W-1] && |quo_in[k][ELEM_W-2:0]))
            begin
                val[k] = ELEM_MIN;
            end
            else
            begin
                val[k] = -mag[k];
            end
        end
        res_next.out_r1c1    = val[0];
        res_next.out_r1c2    = val[1];
        res_next.out_r1c3    = val[2];
        res_next.out_r2c1    = val[3];
        res_next.out_r2c2    = val[4];
        res_next.out_r2c3    = val[5];
        res_next.out_r3c1    = val[6];
        res_next.out_r3c2    = val[7];
        res_next.out_r3c3    = val[8];
        res_next.determinant = side_in.det;
        res_next.singular    = side_in.singular;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_reg <= res_next;
        end
    end

    assign vld = vld_reg;
    assign res = res_reg;

endmodule

/* sv/invert_3x3_matrix.sv */
// ----------------------------------------------------------------------------
// invert_3x3_matrix
// Fully pipelined 3x3 signed fixed-point matrix inverse by the adjugate.
// ----------------------------------------------------------------------------
// Takes one matrix per clock and returns one result per clock while inv_ready
// is high. It holds six stages of cofactor and determinant arithmetic,
// a 33-stage restoring divider (one quotient bit per stage, nine lanes), and
// the output register. A stalled output fills empty stages first, so beats
// are still taken until every stage holds a matrix.
module invert_3x3_matrix
    import inv3_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    output logic mat_ready,
    input  mat_t mat_data,
    output logic inv_valid,
    input  logic inv_ready,
    output inv_t inv_data
);

    localparam int NW  = 2 * ELEM_W + 2 * FRAC_BITS;
    localparam int NST = FRONT_STAGES + QUO_W + 1;

    logic [NST-1:0] vld;
    logic [NST-1:0] en;

    logic [8:0][NW-1:0]    rem_c  [QUO_W];
    logic [8:0][QUO_W-1:0] quo_c  [QUO_W+1];
    logic [DABS_W-1:0]     dabs_c [QUO_W+1];
    side_t                 side_c [QUO_W+1];

    assign en[NST-1] = inv_ready | ~vld[NST-1];

    genvar i;
    generate
        for (i = 0; i < NST - 1; i++)
        begin : g_en
            assign en[i] = en[i+1] | ~vld[i];
        end
    endgenerate

    assign mat_ready = en[0];
    assign inv_valid = vld[NST-1];
    assign quo_c[0]  = '0;

    inv3_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[FRONT_STAGES-1:0]),
        .valid_in (mat_valid),
        .mat      (mat_data),
        .vld      (vld[FRONT_STAGES-1:0]),
        .rem      (rem_c[0]),
        .dabs     (dabs_c[0]),
        .side     (side_c[0])
    );

    genvar j;
    generate
        for (j = 0; j < QUO_W; j++)
        begin : g_div
            if (j < QUO_W - 1)
            begin : g_mid
                inv3_div_step #(
                    .FRAC_BITS (FRAC_BITS),
                    .BIT       (QUO_W - 1 - j)
                ) u_step (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en[FRONT_STAGES+j]),
                    .valid_in (vld[FRONT_STAGES-1+j]),
                    .rem_in   (rem_c[j]),
                    .quo_in   (quo_c[j]),
                    .dabs_in  (dabs_c[j]),
                    .side_in  (side_c[j]),
                    .vld      (vld[FRONT_STAGES+j]),
                    .rem      (rem_c[j+1]),
                    .quo      (quo_c[j+1]),
                    .dabs     (dabs_c[j+1]),
                    .side     (side_c[j+1])
                );
            end
            else
            begin : g_last
                inv3_div_step #(
                    .FRAC_BITS (FRAC_BITS),
                    .BIT       (QUO_W - 1 - j)
                ) u_step (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .en       (en[FRONT_STAGES+j]),
                    .valid_in (vld[FRONT_STAGES-1+j]),
                    .rem_in   (rem_c[j]),
                    .quo_in   (quo_c[j]),
                    .dabs_in  (dabs_c[j]),
                    .side_in  (side_c[j]),
                    .vld      (vld[FRONT_STAGES+j]),
                    .rem      (),
                    .quo      (quo_c[j+1]),
                    .dabs     (dabs_c[j+1]),
                    .side     (side_c[j+1])
                );
            end
        end
    endgenerate

    inv3_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en[NST-1]),
        .valid_in (vld[NST-2]),
        .quo_in   (quo_c[QUO_W]),
        .side_in  (side_c[QUO_W]),
        .vld      (vld[NST-1]),
        .res      (inv_data)
    );

`ifndef ASSERT_OFF
    a_singular_zero_det: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && inv_data.singular |-> inv_data.determinant == '0)
        else $error("singular beat with nonzero determinant");

    a_regular_nonzero_det: assert property (@(posedge clk) disable iff (!rst_n)
        inv_valid && !inv_data.singular |-> inv_data.determinant != '0)
        else $error("regular beat with zero determinant");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !mat_ready |-> (&vld) && !inv_ready)
        else $error("input stalled with an empty stage in the pipeline");
`endif

endmodule

/* test/invert_3x3_matrix_checker.sv */
// ----------------------------------------------------------------------------
// invert_3x3_matrix_checker
// Watches both channels of the matrix inverse, predicts each result with
// exact wide integer arithmetic and compares the whole result, in order.
// ----------------------------------------------------------------------------
module invert_3x3_matrix_checker
    import inv3_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic mat_valid,
    input  logic mat_ready,
    input  mat_t mat_data,
    input  logic inv_valid,
    input  logic inv_ready,
    input  inv_t inv_data,
    output int   errors,
    output int   pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [159:0] wide_t;

    inv_t inverse_q[$];

    function automatic elem_t clamp_elem(wide_t v);
        if (v > wide_t'(ELEM_MAX))
            return ELEM_MAX;
        if (v < wide_t'(ELEM_MIN))
            return ELEM_MIN;
        return elem_t'(v);
    endfunction

    function automatic inv_t invert_predict(mat_t m);
        wide_t e[9];
        wide_t cof[9];
        wide_t det;
        wide_t dabs;
        wide_t dq;
        wide_t num;
        wide_t quo;
        elem_t det_out;
        elem_t res[9];
        inv_t  r;
        e[0] = m.in_r1c1; e[1] = m.in_r1c2; e[2] = m.in_r1c3;
        e[3] = m.in_r2c1; e[4] = m.in_r2c2; e[5] = m.in_r2c3;
        e[6] = m.in_r3c1; e[7] = m.in_r3c2; e[8] = m.in_r3c3;
        cof[0] = e[4] * e[8] - e[7] * e[5];
        cof[1] = e[7] * e[2] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[4] * e[2];
        cof[3] = e[6] * e[5] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[6] * e[2];
        cof[5] = e[3] * e[2] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[6] * e[4];
        cof[7] = e[6] * e[1] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[3] * e[1];
        det  = e[0] * cof[0] + e[1] * cof[3] + e[2] * cof[6];
        dabs = (det < 0) ? -det : det;
        dq   = dabs >>> (2 * FRAC_BITS_DEF);
        if (det < 0)
            dq = -dq;
        det_out = clamp_elem(dq);
        if (det_out == 0)
        begin
            for (int k = 0; k < 9; k++)
                res[k] = (k % 4 == 0) ? elem_t'(1) <<< FRAC_BITS_DEF : '0;
        end
        else
        begin
            for (int k = 0; k < 9; k++)
            begin
                num = (cof[k] < 0) ? -cof[k] : cof[k];
                num = num <<< (2 * FRAC_BITS_DEF);
                quo = num / dabs;
                if ((cof[k] < 0) != (det < 0))
                    quo = -quo;
                res[k] = clamp_elem(quo);
            end
        end
        r.out_r1c1 = res[0]; r.out_r1c2 = res[1]; r.out_r1c3 = res[2];
        r.out_r2c1 = res[3]; r.out_r2c2 = res[4]; r.out_r2c3 = res[5];
        r.out_r3c1 = res[6]; r.out_r3c2 = res[7]; r.out_r3c3 = res[8];
        r.determinant = det_out;
        r.singular    = (det_out == 0);
        return r;
    endfunction

    assign pending = inverse_q.size();

    always @(posedge clk)
    begin
        inv_t want;
        if (rst_n)
        begin
            if (mat_valid && mat_ready)
                inverse_q.push_back(invert_predict(mat_data));
            if (inv_valid && inv_ready)
            begin
                if (inverse_q.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%t unexpected result beat %h", $realtime, inv_data);
                end
                else
                begin
                    want = inverse_q.pop_front();
                    if (want !== inv_data)
                    begin
                        errors++;
                        if (errors <= 10)
                        begin
                            $display("%t mismatch: expected inverse %h det %h sing %b",
                                     $realtime, want[320:33], want.determinant,
                                     want.singular);
                            $display("%t            actual  inverse %h det %h sing %b",
                                     $realtime, inv_data[320:33], inv_data.determinant,
                                     inv_data.singular);
                        end
                    end
                end
            end
        end
    end

endmodule

/* test/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the 3x3 inverse under varying sender gaps and
// receiver stalls: a directed set of corner matrices, then random ones
// mixing small-range, full-range, extreme-valued and singular matrices.
// ----------------------------------------------------------------------------
module testbench
    import inv3_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    logic clk;
    logic rst_n;
    logic mat_valid;
    logic mat_ready;
    mat_t mat_data;
    logic inv_valid;
    logic inv_ready;
    inv_t inv_data;
    int   errors;
    int   pending;
    int   gap_pct;
    int   stall_pct;

    invert_3x3_matrix uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat_data  (mat_data),
        .inv_valid (inv_valid),
        .inv_ready (inv_ready),
        .inv_data  (inv_data)
    );

    invert_3x3_matrix_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_valid (mat_valid),
        .mat_ready (mat_ready),
        .mat_data  (mat_data),
        .inv_valid (inv_valid),
        .inv_ready (inv_ready),
        .inv_data  (inv_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        inv_ready <= ($urandom_range(99) >= stall_pct);
    end

    task automatic send_matrix_start(mat_t m);
        while ($urandom_range(99) < gap_pct)
        begin
            mat_valid <= 1'b0;
            @(posedge clk);
        end
        mat_valid <= 1'b1;
        mat_data  <= m;
    endtask

    task automatic push_matrix(mat_t m);
        logic taken;
        send_matrix_start(m);
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = mat_ready;
            @(posedge clk);
        end
    endtask

    function automatic elem_t rand_elem(int mode);
        case (mode)
            0: return elem_t'($urandom);
            1: return elem_t'($signed($urandom_range(1 << 19)) - (1 <<< 18));
            2: return elem_t'($signed($urandom_range(1 << 13)) - (1 <<< 12));
            default: return $urandom_range(1) ? ELEM_MAX : ELEM_MIN;
        endcase
    endfunction

    function automatic mat_t rand_matrix();
        mat_t m;
        int   mode;
        int   pick;
        pick = $urandom_range(99);
        mode = (pick < 50) ? 1 : (pick < 70) ? 0 : (pick < 85) ? 2 : 3;
        m.in_r1c1 = rand_elem(mode); m.in_r1c2 = rand_elem(mode);
        m.in_r1c3 = rand_elem(mode); m.in_r2c1 = rand_elem(mode);
        m.in_r2c2 = rand_elem(mode); m.in_r2c3 = rand_elem(mode);
        m.in_r3c1 = rand_elem(mode); m.in_r3c2 = rand_elem(mode);
        m.in_r3c3 = rand_elem(mode);
        if ($urandom_range(99) < 10)
        begin
            m.in_r3c1 = m.in_r1c1;
            m.in_r3c2 = m.in_r1c2;
            m.in_r3c3 = m.in_r1c3;
        end
        return m;
    endfunction

    function automatic mat_t diag_matrix(elem_t a, elem_t b, elem_t c);
        mat_t m;
        m = '0;
        m.in_r1c1 = a;
        m.in_r2c2 = b;
        m.in_r3c3 = c;
        return m;
    endfunction

    initial
    begin
        mat_t m;
        elem_t one;
        one       = elem_t'(1) <<< FRAC_BITS_DEF;
        rst_n     = 1'b0;
        mat_valid = 1'b0;
        mat_data  = '0;
        gap_pct   = 0;
        stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_matrix('0);
        push_matrix(diag_matrix(one, one, one));
        push_matrix(diag_matrix(-one, one, -one));
        push_matrix(diag_matrix(one <<< 1, one >>> 2, -(one <<< 3)));
        push_matrix(diag_matrix(ELEM_MAX, ELEM_MAX, ELEM_MAX));
        push_matrix(diag_matrix(ELEM_MIN, ELEM_MIN, ELEM_MIN));
        push_matrix(diag_matrix(ELEM_MIN, ELEM_MAX, ELEM_MIN));
        push_matrix(diag_matrix(elem_t'(1), elem_t'(1), elem_t'(1)));
        push_matrix(diag_matrix(elem_t'(1), one, one));
        push_matrix(diag_matrix(elem_t'(256), one, one));
        push_matrix(diag_matrix(elem_t'(255), one, one));
        push_matrix(diag_matrix(-elem_t'(1), one, one));
        push_matrix({9{ELEM_MAX}});
        push_matrix({9{ELEM_MIN}});
        push_matrix({9{32'hFFFF_FFFF}});
        m = diag_matrix(ELEM_MAX, ELEM_MIN, ELEM_MAX);
        m.in_r1c2 = ELEM_MIN;
        m.in_r2c3 = ELEM_MAX;
        m.in_r3c1 = ELEM_MIN;
        push_matrix(m);
        m = '0;
        m.in_r1c2 = one;
        m.in_r2c3 = one;
        m.in_r3c1 = one;
        push_matrix(m);
        m.in_r1c1 = one <<< 1;
        m.in_r2c2 = -one;
        m.in_r3c3 = one >>> 1;
        push_matrix(m);
        push_matrix({32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                     32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555});

        for (int phase = 0; phase < 4; phase++)
        begin
            gap_pct   = (phase == 1 || phase == 3) ? 66 : 0;
            stall_pct = (phase == 2) ? 66 : (phase == 3) ? 22 : 0;
            if (phase == 3)
                gap_pct = 22;
            for (int n = 0; n < 125; n++)
                push_matrix(rand_matrix());
        end
        mat_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("** invert_3x3_matrix: PASSED **");
        else
            $display("** invert_3x3_matrix: FAILED **");
        $finish;
    end

    initial
    begin
        #1000000;
        $display("** invert_3x3_matrix: FAILED **");
        $finish;
    end

endmodule
